// ===== rtl/tplf_pkg.sv =====
// Package for the triangle pop level finder.
// Holds the payload structs, field widths and configuration register indexes.
// Depends on nothing else.
package tplf_pkg;

    // Coordinate, fraction, level, configuration and index widths.
    localparam int COORD_W = 32;
    localparam int FRAC_W  = 24;
    localparam int LVL_W   = 5;
    localparam int CFG_W   = 32;
    localparam int IDX_W   = 3;

    // Internal level width: holds any level up to 32.
    localparam int LEVEL_INT_W = 6;

    // Configuration register indexes.
    typedef enum logic [IDX_W-1:0] {
        REG_BOX_MIN_X   = 3'd0,
        REG_BOX_MIN_Y   = 3'd1,
        REG_BOX_MIN_Z   = 3'd2,
        REG_SCALE_X     = 3'd3,
        REG_SCALE_Y     = 3'd4,
        REG_SCALE_Z     = 3'd5,
        REG_DISPLAY_LVL = 3'd6
    } cfg_reg_t;

    // One triangle on the input channel.
    typedef struct packed {
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] az;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
        logic signed [COORD_W-1:0] bz;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
        logic                      bad_index;
    } tri_item_t;

    // One result on the output channel.
    typedef struct packed {
        logic [LVL_W-1:0] min_level;
        logic             shown;
    } lvl_item_t;

endpackage

// ===== rtl/triangle_pop_level_finder_core.sv =====
// Triangle pop level finder, top level and only module.
// Normalizes nine coordinates, compares the fractions and finds the first level
// at which the triangle spans more than one cell. Depends on tplf_pkg.

// The block accepts one triangle per clock cycle while tri_stall is low and
// returns its level through its stages (subtract, multiply, clamp and compare,
// leading-zero count). Each stage holds one triangle with its own valid bit; a
// stall on the result side holds the stages that are full, and empty stages keep
// filling, so the input is stalled only when all four stages are occupied. The
// per-cycle work is bounded by the nine parallel 32 x 32 multipliers of the
// second stage. Configuration registers may be written only while the
// pipeline is empty.
module triangle_pop_level_finder_core #(
    parameter int LEVELS = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Triangle input channel.
    input  logic                                tri_valid,
    output logic                                tri_stall,
    input  tplf_pkg::tri_item_t                 tri_item,
    // Level output channel.
    output logic                                lvl_valid,
    input  logic                                lvl_stall,
    output tplf_pkg::lvl_item_t                 lvl_item,
    // Configuration write port.
    input  logic                                cfg_we,
    input  logic [tplf_pkg::IDX_W-1:0]          cfg_index,
    input  logic [tplf_pkg::CFG_W-1:0]          cfg_wdata
);
    import tplf_pkg::*;

    localparam int                     NCOORD   = 9;
    localparam logic [LEVEL_INT_W-1:0] LEVELS_L = LEVEL_INT_W'(LEVELS);
    localparam logic [LEVEL_INT_W-1:0] FRAC_L   = LEVEL_INT_W'(FRAC_W);

    // Configuration registers.
    logic signed [COORD_W-1:0] box_min_reg [3];
    logic [COORD_W-1:0]        scale_reg [3];
    logic [LVL_W-1:0]          display_reg;

    // Pipeline registers.
    logic                      s1_valid_reg;
    logic                      s1_bad_reg;
    logic [COORD_W-1:0]        s1_dist_reg [NCOORD];
    logic                      s2_valid_reg;
    logic                      s2_bad_reg;
    logic [2*COORD_W-1:0]      s2_prod_reg [NCOORD];
    logic                      s3_valid_reg;
    logic                      s3_bad_reg;
    logic [FRAC_W-1:0]         s3_diff_reg;
    logic                      out_valid_reg;
    logic [LEVEL_INT_W-1:0]    out_level_reg;
    logic                      out_shown_reg;

    // Stage advance enables.
    logic                      adv_out;
    logic                      adv3;
    logic                      adv2;
    logic                      adv1;

    // Combinational values per stage.
    logic signed [COORD_W-1:0] coord [NCOORD];
    logic [COORD_W-1:0]        s1_dist_next [NCOORD];
    logic [2*COORD_W-1:0]      s2_prod_next [NCOORD];
    logic [FRAC_W-1:0]         frac [NCOORD];
    logic [FRAC_W-1:0]         s3_diff_next;
    logic [LEVEL_INT_W-1:0]    prefix_len;
    logic [LEVEL_INT_W-1:0]    out_level_next;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                box_min_reg[i] <= '0;
                scale_reg[i]   <= COORD_W'(256);
            end
            display_reg <= LVL_W'(24);
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_BOX_MIN_X:   box_min_reg[0] <= cfg_wdata;
                REG_BOX_MIN_Y:   box_min_reg[1] <= cfg_wdata;
                REG_BOX_MIN_Z:   box_min_reg[2] <= cfg_wdata;
                REG_SCALE_X:     scale_reg[0]   <= cfg_wdata;
                REG_SCALE_Y:     scale_reg[1]   <= cfg_wdata;
                REG_SCALE_Z:     scale_reg[2]   <= cfg_wdata;
                REG_DISPLAY_LVL: display_reg    <= cfg_wdata[LVL_W-1:0];
                default:         ;
            endcase
        end
    end

    // A stage moves on when it is empty or the next stage moves on.
    assign adv_out   = !out_valid_reg || !lvl_stall;
    assign adv3      = !s3_valid_reg || adv_out;
    assign adv2      = !s2_valid_reg || adv3;
    assign adv1      = !s1_valid_reg || adv2;
    assign tri_stall = !adv1;

    // Stage 1: distance above the box minimum; zero when at or below it.
    always_comb
    begin
        logic signed [COORD_W:0] d;
        coord[0] = tri_item.ax;
        coord[1] = tri_item.ay;
        coord[2] = tri_item.az;
        coord[3] = tri_item.bx;
        coord[4] = tri_item.by;
        coord[5] = tri_item.bz;
        coord[6] = tri_item.cx;
        coord[7] = tri_item.cy;
        coord[8] = tri_item.cz;
        for (int i = 0; i < NCOORD; i++)
        begin
            d = {coord[i][COORD_W-1], coord[i]}
                - {box_min_reg[i % 3][COORD_W-1], box_min_reg[i % 3]};
            if (d[COORD_W] || d == '0)
                s1_dist_next[i] = '0;
            else
                s1_dist_next[i] = d[COORD_W-1:0];
        end
    end

    // Stage 2: scale the distance, one multiplier per coordinate.
    always_comb
    begin
        for (int i = 0; i < NCOORD; i++)
            s2_prod_next[i] = s1_dist_reg[i] * scale_reg[i % 3];
    end

    // Stage 3: clamp to a 24-bit fraction and mark every bit position where
    // any axis has vertices that disagree.
    always_comb
    begin
        for (int i = 0; i < NCOORD; i++)
        begin
            if (|s2_prod_reg[i][2*COORD_W-1:FRAC_W+16])
                frac[i] = '1;
            else
                frac[i] = s2_prod_reg[i][FRAC_W+15:16];
        end
        s3_diff_next = '0;
        for (int a = 0; a < 3; a++)
            s3_diff_next = s3_diff_next | (frac[a] ^ frac[a+3]) | (frac[a] ^ frac[a+6]);
    end

    // Stage 4: leading-zero count gives the shared prefix, then cap at LEVELS; a bad index gives LEVELS.
    always_comb
    begin
        prefix_len = FRAC_L;
        for (int b = 0; b < FRAC_W; b++)
        begin
            if (s3_diff_reg[b])
                prefix_len = LEVEL_INT_W'(FRAC_W - 1 - b);
        end
        if (!s3_bad_reg && prefix_len < FRAC_L && prefix_len < LEVELS_L)
            out_level_next = prefix_len;
        else
            out_level_next = LEVELS_L;
    end

    // Valid bits of the pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                s1_valid_reg <= tri_valid;
            if (adv2)
                s2_valid_reg <= s1_valid_reg;
            if (adv3)
                s3_valid_reg <= s2_valid_reg;
            if (adv_out)
                out_valid_reg <= s3_valid_reg;
        end
    end

    // Data registers of the pipeline, loaded only with a valid item.
    always_ff @(posedge clk)
    begin
        if (adv1 && tri_valid)
        begin
            s1_bad_reg <= tri_item.bad_index;
            for (int i = 0; i < NCOORD; i++)
                s1_dist_reg[i] <= s1_dist_next[i];
        end
        if (adv2 && s1_valid_reg)
        begin
            s2_bad_reg <= s1_bad_reg;
            for (int i = 0; i < NCOORD; i++)
                s2_prod_reg[i] <= s2_prod_next[i];
        end
        if (adv3 && s2_valid_reg)
        begin
            s3_bad_reg  <= s2_bad_reg;
            s3_diff_reg <= s3_diff_next;
        end
        if (adv_out && s3_valid_reg)
        begin
            out_level_reg <= out_level_next;
            out_shown_reg <= (out_level_next <= LEVEL_INT_W'(display_reg));
        end
    end

    // Output channel.
    assign lvl_valid          = out_valid_reg;
    assign lvl_item.min_level = out_level_reg[LVL_W-1:0];
    assign lvl_item.shown     = out_shown_reg;

    // An empty output register never holds back the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> !tri_stall)
        else $error("input stalled while output register is empty");

    // A bad index always yields the top level.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && adv_out && s3_bad_reg) |=> (out_level_reg == LEVELS_L))
        else $error("bad index did not force the top level");

    // A delivered level never exceeds LEVELS.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_level_reg <= LEVELS_L))
        else $error("level above LEVELS");

endmodule

// ===== tb/sv/tb_triangle_pop_level_finder_core.sv =====
// Self-checking testbench for triangle_pop_level_finder_core.
// Drives triangles through the valid/stall channels and checks each level against a predictor.
// Depends on tplf_pkg and the core module only.
module tb_triangle_pop_level_finder_core;

    import tplf_pkg::*;

    localparam int LEVELS = 24;
    // Cycles with no transfer on either channel before the run is declared hung.
    localparam int QUIET_LIMIT = 1000;
    // Pipeline depth of the core plus some margin for the final drain.
    localparam int DRAIN_CYCLES = 8;
    localparam logic signed [COORD_W-1:0] MIN_NEG = 32'sh8000_0000;
    localparam logic signed [COORD_W-1:0] MAX_POS = 32'sh7FFF_FFFF;
    localparam logic [CFG_W-1:0] SCALE_MAX = 32'hFFFF_FFFF;
    localparam logic [FRAC_W-1:0] FRAC_TOP = 24'hFF_FFFF;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic tri_valid = 1'b0;
    logic tri_stall;
    tri_item_t tri_item = '0;
    logic lvl_valid;
    logic lvl_stall = 1'b0;
    lvl_item_t lvl_item;
    logic cfg_we = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    // Our copy of the configuration registers.
    logic signed [COORD_W-1:0] box_min [3];
    logic [CFG_W-1:0] box_scale [3];
    logic [LVL_W-1:0] shown_limit;

    lvl_item_t pending_levels [$];
    int mismatches = 0;
    int quiet_cycles = 0;

    // Pacing state: each side switches at random between calm runs and bursty runs.
    bit send_calm = 1'b0;
    int send_run = 0;
    bit take_calm = 1'b0;
    int take_run = 0;
    int unsigned hold_left = 0;
    lvl_item_t want;

    triangle_pop_level_finder_core #(.LEVELS(LEVELS)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .tri_valid(tri_valid),
        .tri_stall(tri_stall),
        .tri_item(tri_item),
        .lvl_valid(lvl_valid),
        .lvl_stall(lvl_stall),
        .lvl_item(lvl_item),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Maps one coordinate into the box as a clamped 24-bit fraction.
    function automatic logic [FRAC_W-1:0] box_fraction(input logic signed [COORD_W-1:0] v,
                                                      input int axis);
        longint d;
        longint unsigned p;
        longint unsigned sc;
        d = longint'(v) - longint'(box_min[axis]);
        if (d <= 0)
            return '0;
        p = d;
        sc = {32'd0, box_scale[axis]};
        p = (p * sc) >> 16;
        if (p > {40'd0, FRAC_TOP})
            return FRAC_TOP;
        return p[FRAC_W-1:0];
    endfunction

    // Least level at which the three vertices fall into different cells.
    function automatic lvl_item_t predict_level(input tri_item_t t);
        logic signed [COORD_W-1:0] va [3];
        logic signed [COORD_W-1:0] vb [3];
        logic signed [COORD_W-1:0] vc [3];
        logic [FRAC_W-1:0] fa;
        logic [FRAC_W-1:0] fb;
        logic [FRAC_W-1:0] fc;
        logic [FRAC_W-1:0] diff;
        int best;
        int n;
        int level;
        lvl_item_t r;
        va[0] = t.ax;
        va[1] = t.ay;
        va[2] = t.az;
        vb[0] = t.bx;
        vb[1] = t.by;
        vb[2] = t.bz;
        vc[0] = t.cx;
        vc[1] = t.cy;
        vc[2] = t.cz;
        best = FRAC_W;
        for (int axis = 0; axis < 3; axis++)
        begin
            fa = box_fraction(va[axis], axis);
            fb = box_fraction(vb[axis], axis);
            fc = box_fraction(vc[axis], axis);
            diff = (fa ^ fb) | (fa ^ fc);
            n = 0;
            while (n < FRAC_W && diff[FRAC_W-1-n] == 1'b0)
                n++;
            if (n < best)
                best = n;
        end
        level = LEVELS;
        if (!t.bad_index && best < FRAC_W && best < LEVELS)
            level = best;
        r.min_level = level[LVL_W-1:0];
        r.shown = (level <= shown_limit);
        return r;
    endfunction

    function automatic tri_item_t make_tri(input logic signed [COORD_W-1:0] a_x, a_y, a_z,
                                           input logic signed [COORD_W-1:0] b_x, b_y, b_z,
                                           input logic signed [COORD_W-1:0] c_x, c_y, c_z,
                                           input logic bad);
        return {a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, bad};
    endfunction

    // Mostly clustered vertices so that common prefixes of every length occur;
    // the rest is full-range noise and extreme values.
    function automatic tri_item_t random_triangle();
        logic signed [COORD_W-1:0] v [9];
        longint span;
        longint base;
        longint delta;
        longint vv;
        int kind;
        int k;
        kind = $urandom_range(0, 9);
        for (int axis = 0; axis < 3; axis++)
        begin
            if (box_scale[axis] == 0)
                span = longint'(1) << 32;
            else
                span = (longint'(1) << 40) / longint'({32'd0, box_scale[axis]});
            if (span >= (longint'(1) << 32))
                base = longint'(box_min[axis]) + longint'($urandom);
            else
                base = longint'(box_min[axis]) + longint'($urandom % (span + 1));
            for (int vert = 0; vert < 3; vert++)
            begin
                k = $urandom_range(0, 33);
                delta = longint'({$urandom, $urandom} & ((64'd1 << k) - 64'd1));
                if ($urandom_range(0, 3) == 0)
                    delta = 0;
                if ($urandom_range(0, 1) == 1)
                    delta = -delta;
                vv = base + delta;
                v[vert * 3 + axis] = vv[COORD_W-1:0];
                if (kind == 0)
                    v[vert * 3 + axis] = $urandom;
                else if (kind == 1)
                begin
                    case ($urandom_range(0, 4))
                        0: v[vert * 3 + axis] = MIN_NEG;
                        1: v[vert * 3 + axis] = MAX_POS;
                        2: v[vert * 3 + axis] = '0;
                        3: v[vert * 3 + axis] = -1;
                        default: v[vert * 3 + axis] = $urandom;
                    endcase
                end
            end
        end
        return make_tri(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8],
                        $urandom_range(0, 11) == 0);
    endfunction

    // One register write; the caller lowers the write enable after the last one.
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        case (idx)
            REG_BOX_MIN_X: box_min[0] = value;
            REG_BOX_MIN_Y: box_min[1] = value;
            REG_BOX_MIN_Z: box_min[2] = value;
            REG_SCALE_X: box_scale[0] = value;
            REG_SCALE_Y: box_scale[1] = value;
            REG_SCALE_Z: box_scale[2] = value;
            REG_DISPLAY_LVL: shown_limit = value[LVL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_config(input logic signed [COORD_W-1:0] mx, my, mz,
                               input logic [CFG_W-1:0] sx, sy, sz,
                               input logic [LVL_W-1:0] disp);
        write_reg(REG_BOX_MIN_X, mx);
        write_reg(REG_BOX_MIN_Y, my);
        write_reg(REG_BOX_MIN_Z, mz);
        write_reg(REG_SCALE_X, sx);
        write_reg(REG_SCALE_Y, sy);
        write_reg(REG_SCALE_Z, sz);
        write_reg(REG_DISPLAY_LVL, {27'd0, disp});
        cfg_we <= 1'b0;
    endtask

    // Presents one triangle and returns in the time step of its transfer.
    task automatic send_triangle(input tri_item_t t);
        int gap;
        if (send_run == 0)
        begin
            send_calm = ($urandom_range(0, 2) == 0);
            send_run = $urandom_range(10, 40);
        end
        send_run--;
        gap = send_calm ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            tri_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tri_item <= t;
        tri_valid <= 1'b1;
        do
            @(posedge clk);
        while (tri_stall);
        pending_levels.insert(pending_levels.size(), predict_level(t));
    endtask

    // Stops sending and waits until every expected level has arrived.
    task automatic finish_phase();
        tri_valid <= 1'b0;
        while (pending_levels.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_reset_config();
        send_triangle(make_tri(0, 0, 0, MAX_POS, 0, 0, 0, 0, 0, 1'b0));
        send_triangle(make_tri(MIN_NEG, MIN_NEG, MIN_NEG, MIN_NEG, MIN_NEG, MIN_NEG,
                               MIN_NEG, MIN_NEG, MIN_NEG, 1'b0));
        send_triangle(make_tri(0, 0, 0, MAX_POS, MAX_POS, MAX_POS, 5, 7, 9, 1'b1));
    endtask

    // Fraction equals the coordinate offset by half the range, shifted down by 8.
    task automatic test_level_boundaries();
        finish_phase();
        load_config(MIN_NEG, MIN_NEG, MIN_NEG, 256, 256, 256, 12);
        send_triangle(make_tri(MIN_NEG, MIN_NEG, MIN_NEG, MIN_NEG, MIN_NEG, MIN_NEG,
                               MIN_NEG, MIN_NEG, MIN_NEG, 1'b0));
        send_triangle(make_tri(MIN_NEG, 0, 0, MAX_POS, 0, 0, 0, 0, 0, 1'b0));
        send_triangle(make_tri(0, 0, 0, 256, 0, 0, 0, 0, 0, 1'b0));
        send_triangle(make_tri(0, 0, 0, 1 << 19, 0, 0, 0, 0, 0, 1'b0));
        send_triangle(make_tri(0, 0, 0, 1 << 18, 0, 0, 0, 0, 0, 1'b0));
        send_triangle(make_tri(0, 0, 0, 255, 0, 0, 0, 0, 0, 1'b0));
        send_triangle(make_tri(0, 0, 0, 1 << 12, 1 << 28, 1 << 12, 0, 0, 0, 1'b0));
        send_triangle(make_tri(0, 0, 0, 0, 0, 0, 0, 0, -1, 1'b0));
        send_triangle(make_tri(MIN_NEG, MAX_POS, 0, MAX_POS, MIN_NEG, -1, 0, 3, 1, 1'b1));
    endtask

    // Coordinates below the box clamp to zero and beyond it to the top fraction.
    task automatic test_box_clamping();
        finish_phase();
        load_config(0, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0);
        send_triangle(make_tri(0, 0, 0, 32'h0080_0000, 0, 0, 0, 0, 0, 1'b0));
        send_triangle(make_tri(1234, 99, 7, 1234, 99, 7, 1234, 99, 7, 1'b0));
        send_triangle(make_tri(-5, 0, 0, MIN_NEG, 0, 0, 0, 0, 0, 1'b0));
        send_triangle(make_tri(MAX_POS, 0, 0, 32'h0100_0000, 0, 0, 32'h00FF_FFFF, 0, 0, 1'b0));
        send_triangle(make_tri(2, 0, 0, 3, 0, 0, 2, 0, 0, 1'b0));
        finish_phase();
        load_config(0, 0, 0, SCALE_MAX, SCALE_MAX, SCALE_MAX, 24);
        send_triangle(make_tri(1, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
        send_triangle(make_tri(MAX_POS, 0, 0, -1, 0, 0, 1, 0, 0, 1'b0));
    endtask

    // With no scale every fraction is zero, so every triangle is degenerate.
    task automatic test_zero_scale();
        finish_phase();
        load_config(MAX_POS, MAX_POS, MAX_POS, 0, 0, 0, 24);
        send_triangle(make_tri(MAX_POS, MIN_NEG, 0, MIN_NEG, MAX_POS, -1, 1, 2, 3, 1'b0));
        send_triangle(make_tri(MIN_NEG, MIN_NEG, MIN_NEG, MAX_POS, MAX_POS, MAX_POS,
                               0, 0, 0, 1'b0));
    endtask

    task automatic test_random_traffic();
        logic signed [COORD_W-1:0] mins [3];
        logic [CFG_W-1:0] scales [3];
        logic [LVL_W-1:0] disp;
        for (int phase = 0; phase < 10; phase++)
        begin
            for (int axis = 0; axis < 3; axis++)
            begin
                mins[axis] = $urandom;
                if ($urandom_range(0, 5) == 0)
                    mins[axis] = $urandom_range(0, 1) ? MIN_NEG : MAX_POS;
                case ($urandom_range(0, 7))
                    0: scales[axis] = 256;
                    1: scales[axis] = SCALE_MAX;
                    2: scales[axis] = $urandom;
                    3: scales[axis] = 0;
                    default: scales[axis] = 32'd1 << $urandom_range(4, 28);
                endcase
            end
            disp = $urandom_range(0, 24);
            if (phase == 0)
                disp = 0;
            else if (phase == 1)
                disp = 24;
            else if (phase == 2)
            begin
                mins = '{MIN_NEG, MIN_NEG, MIN_NEG};
                scales = '{SCALE_MAX, SCALE_MAX, SCALE_MAX};
            end
            else if (phase == 3)
            begin
                mins = '{MAX_POS, MAX_POS, MAX_POS};
                scales = '{1, 1, 1};
            end
            finish_phase();
            load_config(mins[0], mins[1], mins[2], scales[0], scales[1], scales[2], disp);
            repeat (45) send_triangle(random_triangle());
        end
    endtask

    // Result side: random stall after each transfer, and the check of each level.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (lvl_valid && !lvl_stall)
            begin
                if (pending_levels.size() == 0)
                begin
                    $display("%0t: unexpected level transfer: expected none, %s %0d shown %0b",
                             $time, "actual level", lvl_item.min_level, lvl_item.shown);
                    mismatches++;
                end
                else
                begin
                    want = pending_levels.pop_front();
                    if (lvl_item.min_level !== want.min_level)
                    begin
                        $display("%0t: min_level mismatch: expected %0d, actual %0d",
                                 $time, want.min_level, lvl_item.min_level);
                        mismatches++;
                    end
                    if (lvl_item.shown !== want.shown)
                    begin
                        $display("%0t: shown mismatch: expected %0b, actual %0b",
                                 $time, want.shown, lvl_item.shown);
                        mismatches++;
                    end
                end
                if (take_run == 0)
                begin
                    take_calm = ($urandom_range(0, 2) == 0);
                    take_run = $urandom_range(10, 40);
                end
                take_run--;
                hold_left = take_calm ? 0 : $urandom_range(0, 13);
                lvl_stall <= (hold_left != 0);
            end
            else if (hold_left > 0)
            begin
                hold_left--;
                lvl_stall <= (hold_left != 0);
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((tri_valid && !tri_stall) || (lvl_valid && !lvl_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
                $display("tb_triangle_pop_level_finder_core: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        // Registers as they come out of reset.
        box_min = '{0, 0, 0};
        box_scale = '{256, 256, 256};
        shown_limit = 24;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_config();
        test_level_boundaries();
        test_box_clamping();
        test_zero_scale();
        test_random_traffic();
        finish_phase();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb_triangle_pop_level_finder_core: PASS");
        else
            $display("tb_triangle_pop_level_finder_core: FAIL");
        $finish;
    end

endmodule
